// ===== rtl/receiver_delay_window_control_assert.svh =====
// assertion macros used by the checker module
`ifndef RECEIVER_DELAY_WINDOW_CONTROL_ASSERT_SVH
`define RECEIVER_DELAY_WINDOW_CONTROL_ASSERT_SVH

// same-cycle implication
`define RDWC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rdwc same-cycle check failed");

// next-cycle implication
`define RDWC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdwc next-cycle check failed");

`endif

// ===== rtl/rdwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_pkg
// Types, codes and defaults of the receiver delay window control block.
// ----------------------------------------------------------------------------
package rdwc_pkg;

    localparam int BASE_HISTORY_LEN_DEF = 10;
    localparam int NOISE_FILTER_LEN_DEF = 4;
    localparam int EPOCH_MS_DEF         = 60000;

    localparam logic [30:0] CUT_MAX = 31'h7FFF_FFFF;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET,
        CFG_GAIN,
        CFG_SS_EN,
        CFG_MIN_SEG,
        CFG_INIT_SEG,
        CFG_SEG_SIZE
    } cfg_idx_t;

    localparam logic [15:0] TARGET_RST   = 16'd100;
    localparam logic [15:0] GAIN_RST     = 16'd256;
    localparam logic        SS_EN_RST    = 1'b1;
    localparam logic [7:0]  MIN_SEG_RST  = 8'd2;
    localparam logic [7:0]  INIT_SEG_RST = 8'd1;
    localparam logic [15:0] SEG_SIZE_RST = 16'd536;

    typedef enum logic [1:0] {
        MW_NOP,
        MW_PUSH,
        MW_REPLACE,
        MW_CLEAR
    } mw_op_t;

    typedef struct packed {
        mw_op_t      op;
        logic [31:0] sample;
    } mw_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        empty;
        logic [31:0] min_value;
    } mw_stat_t;

    typedef struct packed {
        logic start;
        logic sat_half;
    } md_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } md_stat_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL_GA,
        MD_MUL_SEG,
        MD_MUL_LO,
        MD_MUL_HI,
        MD_MUL_DEN,
        MD_DIV,
        MD_DONE
    } md_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_WAIT,
        ST_RETX,
        ST_BRANCH,
        ST_MULDIV,
        ST_DRAIN_A,
        ST_DRAIN_B,
        ST_DRAIN_C,
        ST_FLOOR,
        ST_DONE
    } ctl_state_t;

endpackage

// ===== rtl/rdwc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_if
// Segment, result and configuration channels of the window control block.
// ----------------------------------------------------------------------------
interface rdwc_seg_if;
    logic        valid;
    logic        ready;
    logic        has_timestamp;
    logic [31:0] ts_value;
    logic [31:0] seg_seq;
    logic [15:0] packet_bytes;
    logic [3:0]  header_words;
    logic [31:0] now_ms;

    modport source (output valid, has_timestamp, ts_value, seg_seq, packet_bytes,
                    header_words, now_ms, input ready);
    modport sink   (input valid, has_timestamp, ts_value, seg_seq, packet_bytes,
                    header_words, now_ms, output ready);
endinterface

interface rdwc_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] window_bytes;
    logic [31:0] slow_start_threshold;
    logic [30:0] reduction_left;
    logic [31:0] queuing_delay_ms;
    logic        window_updated;

    modport source (output valid, window_bytes, slow_start_threshold, reduction_left,
                    queuing_delay_ms, window_updated, input ready);
    modport sink   (input valid, window_bytes, slow_start_threshold, reduction_left,
                    queuing_delay_ms, window_updated, output ready);
endinterface

interface rdwc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rdwc_pkg::CFG_IDX_W-1:0] index;
    logic [15:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/rdwc_min_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_min_window
// Min-tracking sample window holding up to LEN-1 delay samples, oldest
// dropped first; rescans for the minimum one entry per cycle after a drop.
// ----------------------------------------------------------------------------
module rdwc_min_window #(
    parameter int LEN = rdwc_pkg::NOISE_FILTER_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rdwc_pkg::mw_cmd_t  cmd,
    output rdwc_pkg::mw_stat_t stat
);
    import rdwc_pkg::*;

    localparam int DEPTH = LEN - 1;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(LEN);

    logic [31:0]   samp_reg  [DEPTH];
    logic [31:0]   samp_next [DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic          scan_reg, scan_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [31:0]   min_reg, min_next;
    logic [31:0]   last_reg, last_next;
    logic [31:0]   rd;

    always_comb
    begin
        samp_next  = samp_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        idx_next   = idx_reg;
        min_next   = min_reg;
        last_next  = last_reg;
        rd         = samp_reg[idx_reg];
        if (scan_reg)
        begin
            if (idx_reg == '0 || rd < min_reg)
            begin
                min_next = rd;
            end
            if (idx_reg == IW'(count_reg - CW'(1)))
            begin
                scan_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IW'(1);
            end
        end
        else
        begin
            unique case (cmd.op)
                MW_PUSH:
                begin
                    last_next = cmd.sample;
                    if (count_reg == '0)
                    begin
                        samp_next[0] = cmd.sample;
                        count_next   = CW'(1);
                        min_next     = cmd.sample;
                    end
                    else if (count_reg == CW'(DEPTH))
                    begin
                        // drop the oldest, then rescan for the minimum
                        for (int i = 0; i < DEPTH - 1; i++)
                        begin
                            samp_next[i] = samp_reg[i + 1];
                        end
                        samp_next[DEPTH-1] = cmd.sample;
                        scan_next          = 1'b1;
                        idx_next           = '0;
                    end
                    else
                    begin
                        samp_next[IW'(count_reg)] = cmd.sample;
                        count_next                = count_reg + CW'(1);
                        if (cmd.sample < min_reg)
                        begin
                            min_next = cmd.sample;
                        end
                    end
                end
                MW_REPLACE:
                begin
                    if (cmd.sample < last_reg)
                    begin
                        samp_next[IW'(count_reg - CW'(1))] = cmd.sample;
                        last_next                          = cmd.sample;
                        if (cmd.sample < min_reg)
                        begin
                            min_next = cmd.sample;
                        end
                    end
                end
                MW_CLEAR:
                begin
                    count_next = '0;
                end
                MW_NOP:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scan_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            scan_reg  <= scan_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        min_reg  <= min_next;
        last_reg <= last_next;
    end

    assign stat.busy      = scan_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.min_value = min_reg;

endmodule

// ===== rtl/rdwc_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_muldiv
// Shared 48x16 multiplier and restoring divider for the window delta:
// gain*acked*seg*diff / (256*target*window), saturated to the cap.
// ----------------------------------------------------------------------------
module rdwc_muldiv (
    input  logic               clk,
    input  logic               rst_n,
    input  rdwc_pkg::md_ctl_t  ctl,
    input  logic [15:0]        gain,
    input  logic [15:0]        acked,
    input  logic [15:0]        seg_size,
    input  logic [15:0]        target,
    input  logic [31:0]        window,
    input  logic [31:0]        diff,
    output rdwc_pkg::md_stat_t stat,
    output logic [31:0]        result
);
    import rdwc_pkg::*;

    localparam int NUM_W = 80;
    localparam int DEN_W = 56;
    localparam int CNT_W = $clog2(NUM_W);

    md_state_t        state_reg, state_next;
    logic [47:0]      a_reg, a_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [31:0]      q_reg, q_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      result_reg, result_next;

    logic [47:0]      mul_a;
    logic [15:0]      mul_b;
    logic [63:0]      prod;
    logic [31:0]      win_eff;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [31:0]      cap;

    assign prod    = 64'(mul_a) * 64'(mul_b);
    assign win_eff = (window == '0) ? 32'd1 : window;
    assign cap     = ctl.sat_half ? {1'b0, CUT_MAX} : '1;

    always_comb
    begin
        state_next  = state_reg;
        a_next      = a_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        ovf_next    = ovf_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        mul_a       = a_reg;
        mul_b       = diff[15:0];
        rem_sh      = {rem_reg[DEN_W-1:0], num_reg[NUM_W-1]};
        ge          = (rem_sh >= {1'b0, den_reg});
        unique case (state_reg)
            MD_IDLE:
            begin
                if (ctl.start)
                begin
                    state_next = MD_MUL_GA;
                end
            end
            MD_MUL_GA:
            begin
                mul_a      = {32'd0, gain};
                mul_b      = acked;
                a_next     = prod[47:0];
                state_next = MD_MUL_SEG;
            end
            MD_MUL_SEG:
            begin
                mul_b      = seg_size;
                a_next     = prod[47:0];
                state_next = MD_MUL_LO;
            end
            MD_MUL_LO:
            begin
                mul_b      = diff[15:0];
                num_next   = {16'd0, prod};
                state_next = MD_MUL_HI;
            end
            MD_MUL_HI:
            begin
                mul_b      = diff[31:16];
                num_next   = num_reg + {prod, 16'd0};
                state_next = MD_MUL_DEN;
            end
            MD_MUL_DEN:
            begin
                mul_a    = {16'd0, win_eff};
                mul_b    = target;
                den_next = {prod[47:0], 8'd0};
                rem_next = '0;
                q_next   = '0;
                ovf_next = 1'b0;
                cnt_next = CNT_W'(NUM_W - 1);
                if (target == '0)
                begin
                    result_next = '0;
                    state_next  = MD_DONE;
                end
                else
                begin
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                rem_next = ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                q_next   = {q_reg[30:0], ge};
                ovf_next = ovf_reg | q_reg[31];
                if (cnt_reg == '0)
                begin
                    if (ovf_next || q_next > cap)
                    begin
                        result_next = cap;
                    end
                    else
                    begin
                        result_next = q_next;
                    end
                    state_next = MD_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        ovf_reg    <= ovf_next;
        result_reg <= result_next;
    end

    assign stat.busy = (state_reg != MD_IDLE);
    assign stat.done = (state_reg == MD_DONE);
    assign result    = result_reg;

endmodule

// ===== rtl/receiver_delay_window_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receiver_delay_window_control
// Receiver-side delay-based window control: one result word per segment.
// ----------------------------------------------------------------------------
// segment channel: one word per received segment; ready is high only while
//   the sequencer is idle, so one segment is in work at a time
// result channel: one word per segment, held in an output register; the next
//   segment is taken while a result still waits, and a stalled receiver only
//   holds the sequencer in its last step until the register frees up
// cfg channel: always ready, write registers between segments only
// per segment: the word is captured; the prep step sends a segment without
//   a timestamp straight to the result step, else the sample windows take
//   the sample and the sequencer waits while either rescans for its minimum
//   after dropping its oldest entry, checks for a retransmission and goes to
//   draining a pending cut, to slow start or to the delay law: the shared
//   48x16 multiplier (five multiply steps, an 80-step restoring divide, one
//   done step), on a decrease the drain steps, then the floor step
// a new segment is taken only once the last one's result word is loaded;
//   ready returns together with result valid
// reset: window 0, threshold all ones, no pending cut, empty sample windows,
//   registers at their defaults
// ----------------------------------------------------------------------------
module receiver_delay_window_control #(
    parameter int BASE_HISTORY_LEN = rdwc_pkg::BASE_HISTORY_LEN_DEF,
    parameter int NOISE_FILTER_LEN = rdwc_pkg::NOISE_FILTER_LEN_DEF,
    parameter int EPOCH_MS         = rdwc_pkg::EPOCH_MS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    rdwc_cfg_if.sink cfg,
    rdwc_seg_if.sink segment,
    rdwc_res_if.source result
);
    import rdwc_pkg::*;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // configuration
    logic [15:0] target_reg, gain_reg, seg_size_reg;
    logic        ss_en_reg;
    logic [7:0]  min_seg_reg, init_seg_reg;

    ctl_state_t  state_reg, state_next;
    logic [31:0] window_reg, window_next;
    logic [31:0] thr_reg, thr_next;
    logic [30:0] pc_reg, pc_next;
    logic [31:0] hseq_reg, hseq_next;
    logic [31:0] hstamp_reg, hstamp_next;
    logic [31:0] epoch_reg, epoch_next;

    // captured segment word
    logic        has_ts_reg;
    logic [31:0] ts_reg, seq_reg, now_reg;
    logic [15:0] pkt_reg;
    logic [3:0]  hdr_reg;

    // per-segment work registers
    logic [15:0] acked_reg, acked_next;
    logic [23:0] minw_reg, minw_next;
    logic        retx_reg, retx_next;
    logic        slow_reg, slow_next;
    logic [31:0] queuing_reg, queuing_next;
    logic        upd_reg, upd_next;
    logic        dec_reg, dec_next;
    logic        law_reg, law_next;
    logic [31:0] diff_reg, diff_next;
    logic [31:0] tmp_reg, tmp_next;
    logic        tmp_ok_reg, tmp_ok_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_window_reg, out_window_next;
    logic [31:0] out_thr_reg, out_thr_next;
    logic [30:0] out_rl_reg, out_rl_next;
    logic [31:0] out_q_reg, out_q_next;
    logic        out_upd_reg, out_upd_next;

    mw_cmd_t     noise_cmd, base_cmd;
    mw_stat_t    noise_stat, base_stat;
    md_ctl_t     md_ctl;
    md_stat_t    md_stat;
    logic [31:0] md_result;

    logic        in_acc;
    logic [31:0] owd, seq_diff, minw32, half, cut_thr, cut_w, tgt32;
    logic [15:0] acked_c;
    logic [5:0]  hdr_bytes;
    logic        seq_ae;
    ctl_state_t  drain_exit;

    assign in_acc        = segment.valid && segment.ready;
    assign segment.ready = (state_reg == ST_IDLE);
    assign cfg.ready     = 1'b1;

    assign owd       = now_reg - ts_reg;
    assign seq_diff  = seq_reg - hseq_reg;
    // seq at or after the highest one seen; a half-space tie counts as after when seq is the smaller plain value
    assign seq_ae    = !seq_diff[31] || (seq_diff == 32'h8000_0000 && seq_reg < hseq_reg);
    assign hdr_bytes = {hdr_reg, 2'b00};
    assign acked_c   = (pkt_reg > 16'(hdr_bytes)) ? (pkt_reg - 16'(hdr_bytes)) : 16'd0;
    assign minw32    = 32'(minw_reg);
    assign half      = {1'b0, window_reg[31:1]};
    assign cut_thr   = (half >= minw32) ? half : minw32;
    assign cut_w     = (window_reg > cut_thr) ? (window_reg - cut_thr) : 32'd0;
    assign tgt32     = 32'(target_reg);
    assign drain_exit = law_reg ? ST_FLOOR : ST_DONE;

    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        thr_next        = thr_reg;
        pc_next         = pc_reg;
        hseq_next       = hseq_reg;
        hstamp_next     = hstamp_reg;
        epoch_next      = epoch_reg;
        acked_next      = acked_reg;
        minw_next       = minw_reg;
        retx_next       = retx_reg;
        slow_next       = slow_reg;
        queuing_next    = queuing_reg;
        upd_next        = upd_reg;
        dec_next        = dec_reg;
        law_next        = law_reg;
        diff_next       = diff_reg;
        tmp_next        = tmp_reg;
        tmp_ok_next     = tmp_ok_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_window_next = out_window_reg;
        out_thr_next    = out_thr_reg;
        out_rl_next     = out_rl_reg;
        out_q_next      = out_q_reg;
        out_upd_next    = out_upd_reg;
        noise_cmd       = '{op: MW_NOP, sample: owd};
        base_cmd        = '{op: MW_NOP, sample: owd};
        md_ctl          = '{start: 1'b0, sat_half: dec_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (!has_ts_reg || ts_reg == '0)
                begin
                    queuing_next = '0;
                    upd_next     = 1'b0;
                    state_next   = ST_DONE;
                end
                else
                begin
                    upd_next = 1'b1;
                    if (window_reg == '0 && seg_size_reg != '0)
                    begin
                        window_next = 32'(init_seg_reg) * 32'(seg_size_reg);
                    end
                    acked_next = acked_c;
                    if (seq_ae)
                    begin
                        hseq_next   = seq_reg + 32'(acked_c);
                        hstamp_next = ts_reg;
                    end
                    // a retransmission can only be seen when the highest seq stays
                    retx_next = !seq_ae && (ts_reg > hstamp_reg) && (pc_reg == '0);
                    minw_next = min_seg_reg * seg_size_reg;
                    noise_cmd.op = MW_PUSH;
                    if (base_stat.empty)
                    begin
                        base_cmd.op = MW_PUSH;
                    end
                    else if ((now_reg - epoch_reg) > 32'(EPOCH_MS))
                    begin
                        epoch_next  = now_reg;
                        base_cmd.op = MW_PUSH;
                    end
                    else
                    begin
                        base_cmd.op = MW_REPLACE;
                    end
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (!noise_stat.busy && !base_stat.busy)
                begin
                    queuing_next = (noise_stat.min_value > base_stat.min_value) ?
                                   (noise_stat.min_value - base_stat.min_value) : 32'd0;
                    slow_next    = ss_en_reg && (window_reg < thr_reg);
                    state_next   = ST_RETX;
                end
            end
            ST_RETX:
            begin
                if (retx_reg)
                begin
                    thr_next     = cut_thr;
                    pc_next      = (cut_w > {1'b0, CUT_MAX}) ? CUT_MAX : cut_w[30:0];
                    noise_cmd.op = MW_CLEAR;
                end
                state_next = ST_BRANCH;
            end
            ST_BRANCH:
            begin
                if (pc_reg != '0)
                begin
                    law_next   = 1'b0;
                    state_next = ST_DRAIN_A;
                end
                else if (slow_reg)
                begin
                    window_next = sat_add(window_reg, 32'(acked_reg));
                    state_next  = ST_DONE;
                end
                else
                begin
                    law_next = 1'b1;
                    if (queuing_reg < tgt32)
                    begin
                        diff_next = tgt32 - queuing_reg;
                        dec_next  = 1'b0;
                    end
                    else
                    begin
                        diff_next = queuing_reg - tgt32;
                        dec_next  = 1'b1;
                    end
                    md_ctl.start = 1'b1;
                    state_next   = ST_MULDIV;
                end
            end
            ST_MULDIV:
            begin
                if (md_stat.done)
                begin
                    if (!dec_reg)
                    begin
                        window_next = sat_add(window_reg, md_result);
                        state_next  = ST_FLOOR;
                    end
                    else
                    begin
                        pc_next    = md_result[30:0];
                        state_next = ST_DRAIN_A;
                    end
                end
            end
            ST_DRAIN_A:
            begin
                if (pc_reg == '0)
                begin
                    state_next = drain_exit;
                end
                else if (32'(acked_reg) >= 32'(pc_reg))
                begin
                    window_next = (window_reg > 32'(pc_reg)) ? (window_reg - 32'(pc_reg))
                                                             : minw32;
                    pc_next     = '0;
                    state_next  = ST_DRAIN_C;
                end
                else
                begin
                    tmp_ok_next = window_reg > 32'(acked_reg);
                    tmp_next    = window_reg - 32'(acked_reg);
                    state_next  = ST_DRAIN_B;
                end
            end
            ST_DRAIN_B:
            begin
                if (tmp_ok_reg && tmp_reg >= minw32)
                begin
                    window_next = tmp_reg;
                    pc_next     = pc_reg - 31'(acked_reg);
                end
                else
                begin
                    window_next = minw32;
                    pc_next     = '0;
                end
                state_next = ST_DRAIN_C;
            end
            ST_DRAIN_C:
            begin
                // cut finished or window at its floor: settle the threshold
                if (pc_reg == '0 || window_reg == minw32)
                begin
                    pc_next = '0;
                    if (window_reg < thr_reg)
                    begin
                        thr_next = window_reg;
                    end
                end
                state_next = drain_exit;
            end
            ST_FLOOR:
            begin
                if (window_reg < minw32)
                begin
                    window_next = minw32;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_window_next = window_reg;
                    out_thr_next    = thr_reg;
                    out_rl_next     = pc_reg;
                    out_q_next      = queuing_reg;
                    out_upd_next    = upd_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= TARGET_RST;
            gain_reg     <= GAIN_RST;
            ss_en_reg    <= SS_EN_RST;
            min_seg_reg  <= MIN_SEG_RST;
            init_seg_reg <= INIT_SEG_RST;
            seg_size_reg <= SEG_SIZE_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_TARGET:   target_reg   <= cfg.data;
                CFG_GAIN:     gain_reg     <= cfg.data;
                CFG_SS_EN:    ss_en_reg    <= cfg.data[0];
                CFG_MIN_SEG:  min_seg_reg  <= cfg.data[7:0];
                CFG_INIT_SEG: init_seg_reg <= cfg.data[7:0];
                CFG_SEG_SIZE: seg_size_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_reg     <= '0;
            thr_reg        <= '1;
            pc_reg         <= '0;
            hseq_reg       <= '0;
            hstamp_reg     <= '0;
            epoch_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_window_reg <= '0;
            out_thr_reg    <= '0;
            out_rl_reg     <= '0;
            out_q_reg      <= '0;
            out_upd_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_reg     <= window_next;
            thr_reg        <= thr_next;
            pc_reg         <= pc_next;
            hseq_reg       <= hseq_next;
            hstamp_reg     <= hstamp_next;
            epoch_reg      <= epoch_next;
            out_valid_reg  <= out_valid_next;
            out_window_reg <= out_window_next;
            out_thr_reg    <= out_thr_next;
            out_rl_reg     <= out_rl_next;
            out_q_reg      <= out_q_next;
            out_upd_reg    <= out_upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            has_ts_reg <= segment.has_timestamp;
            ts_reg     <= segment.ts_value;
            seq_reg    <= segment.seg_seq;
            pkt_reg    <= segment.packet_bytes;
            hdr_reg    <= segment.header_words;
            now_reg    <= segment.now_ms;
        end
        acked_reg   <= acked_next;
        minw_reg    <= minw_next;
        retx_reg    <= retx_next;
        slow_reg    <= slow_next;
        queuing_reg <= queuing_next;
        upd_reg     <= upd_next;
        dec_reg     <= dec_next;
        law_reg     <= law_next;
        diff_reg    <= diff_next;
        tmp_reg     <= tmp_next;
        tmp_ok_reg  <= tmp_ok_next;
    end

    rdwc_min_window #(
        .LEN (NOISE_FILTER_LEN)
    ) u_noise (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (noise_cmd),
        .stat  (noise_stat)
    );

    rdwc_min_window #(
        .LEN (BASE_HISTORY_LEN)
    ) u_base (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (base_cmd),
        .stat  (base_stat)
    );

    rdwc_muldiv u_muldiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (md_ctl),
        .gain     (gain_reg),
        .acked    (acked_reg),
        .seg_size (seg_size_reg),
        .target   (target_reg),
        .window   (window_reg),
        .diff     (diff_reg),
        .stat     (md_stat),
        .result   (md_result)
    );

    assign result.valid                = out_valid_reg;
    assign result.window_bytes         = out_window_reg;
    assign result.slow_start_threshold = out_thr_reg;
    assign result.reduction_left       = out_rl_reg;
    assign result.queuing_delay_ms     = out_q_reg;
    assign result.window_updated       = out_upd_reg;

endmodule

// ===== rtl/rdwc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdwc_checker
// Port-level checks of the receiver delay window control block.
// ----------------------------------------------------------------------------
`include "receiver_delay_window_control_assert.svh"

module rdwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_window,
    input logic [31:0] out_q,
    input logic        out_upd
);
    // stalled result word holds
    `RDWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_window))
    // one segment in work at a time
    `RDWC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // no result is produced in the cycle right after a segment is taken
    `RDWC_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, $stable(out_window))
    // untimed segment reports no queuing delay
    `RDWC_ASSERT_SAME(a_untimed_zero_q, out_valid && !out_upd, out_q == 32'd0)

endmodule

bind receiver_delay_window_control rdwc_checker u_rdwc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (segment.valid),
    .in_ready   (segment.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_window (result.window_bytes),
    .out_q      (result.queuing_delay_ms),
    .out_upd    (result.window_updated)
);
